[sv/grs_pkg.sv]
`default_nettype none

package grs_pkg;

  localparam int COUNT_W  = 32;
  localparam int FACTOR_W = 8;
  localparam int SPLIT_W  = 7;
  localparam int STATUS_W = 2;
  localparam int PROD_W   = COUNT_W + FACTOR_W;

  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 8'd2;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_RATIO_OVF = 2'd1,
    STATUS_SUM_OVF   = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    store;
    logic    begin_scan;
    logic    load_cur;
    logic    down_step;
    logic    split_hi;
    logic    up_init;
    logic    up_step;
    logic    finish;
    status_t code;
  } cmd_t;

  // Conditions reported back by the datapath.
  typedef struct packed {
    logic n_le1;
    logic ratio_ovf;
    logic ratio_break;
    logic idx_one;
    logic up_ovf;
    logic up_stop;
    logic up_last;
  } stat_t;

endpackage

`default_nettype wire

[sv/geometric_repack_split_unit.sv]
`default_nettype none

// Channel        Direction  Signals                         Transaction
// -------------  ---------  ------------------------------  ---------------------------
// pack input     in         start, busy, object_count, last start high and busy low
// configuration  in         cfg_valid, cfg_ready, cfg_data  cfg_valid and cfg_ready high
// result         out        result_valid, split, status     result_valid high, one cycle
//
// A pack without the last flag leaves busy low, so counts may stream at one per
// clock. A transaction carrying the last flag keeps busy high while the set is scanned
// through the single read port of the count memory, which delivers one stored count
// per cycle to the downward scan and then to the upward pass. The result strobe is
// registered from the finish command and rises in the next cycle; it cannot be stalled.
// Reset is synchronous: it empties the set, clears the strobe and restores the factor to 2.

module geometric_repack_split_unit #(
  parameter int MAX_PACKS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [grs_pkg::COUNT_W-1:0]   object_count,
  input  wire logic                          last,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [grs_pkg::FACTOR_W-1:0]  cfg_data,
  output logic                               result_valid,
  output logic      [grs_pkg::SPLIT_W-1:0]   split,
  output logic      [grs_pkg::STATUS_W-1:0]  status
);

  grs_pkg::cmd_t    cmd;
  grs_pkg::stat_t   stat;
  grs_pkg::status_t status_code;

  // The factor register is only written between sets, while no computation runs.
  assign cfg_ready = !busy;

  // The controller walks the scan phases; the datapath holds the counts and the sums.
  grs_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .last (last),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  grs_datapath #(
    .MAX_PACKS(MAX_PACKS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .object_count(object_count),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .result_valid(result_valid),
    .split       (split),
    .status      (status_code)
  );

  assign status = status_code;

endmodule

`default_nettype wire

[sv/grs_ram.sv]
`default_nettype none

module grs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/grs_datapath.sv]
`default_nettype none

module grs_datapath #(
  parameter int MAX_PACKS = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire grs_pkg::cmd_t                    cmd,
  output grs_pkg::stat_t                        stat,
  input  wire logic [grs_pkg::COUNT_W-1:0]      object_count,
  input  wire logic                             cfg_we,
  input  wire logic [grs_pkg::FACTOR_W-1:0]     cfg_data,
  output logic                                  result_valid,
  output logic      [grs_pkg::SPLIT_W-1:0]      split,
  output grs_pkg::status_t                      status
);

  localparam int IW = $clog2(MAX_PACKS);
  localparam int CW = $clog2(MAX_PACKS + 1);
  localparam int CNT_W = grs_pkg::COUNT_W;
  localparam int PW = grs_pkg::PROD_W;
  localparam int SPLIT_W_EXT = grs_pkg::SPLIT_W + CW;

  logic [CW-1:0]                    pack_total;
  logic [IW-1:0]                    idx;
  logic [CNT_W-1:0]                 cur;
  logic [CNT_W-1:0]                 sum;
  logic [CW-1:0]                    split_reg;
  logic [grs_pkg::FACTOR_W-1:0]     factor;
  logic [CW-1:0]                    split_out;

  logic                             ram_we;
  logic [IW-1:0]                    raddr;
  logic [CNT_W-1:0]                 rdata;

  logic [PW-1:0]                    prod_down;
  logic [PW-1:0]                    prod_up;
  logic [CNT_W:0]                   sum_add;
  logic                             in_prefix;
  logic                             up_prod_ovf;
  logic                             up_lt;
  logic [SPLIT_W_EXT-1:0]           split_wide;

  assign ram_we = cmd.store && (pack_total < CW'(MAX_PACKS));

  always_comb begin
    priority if (cmd.begin_scan) begin
      raddr = IW'(pack_total - CW'(1));
    end else if (cmd.load_cur) begin
      raddr = idx - IW'(1);
    end else if (cmd.down_step) begin
      raddr = idx - IW'(2);
    end else if (cmd.up_init) begin
      raddr = '0;
    end else if (cmd.up_step) begin
      raddr = idx + IW'(1);
    end else begin
      raddr = idx;
    end
  end

  grs_ram #(
    .WIDTH(CNT_W),
    .DEPTH(MAX_PACKS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(pack_total[IW-1:0]),
    .wdata(object_count),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Downward scan: rdata holds the lower count of the pair, cur the upper.
  assign prod_down = PW'(factor) * PW'(rdata);

  // Upward pass: prefix sum below the split, then absorb.
  assign prod_up     = PW'(factor) * PW'(sum);
  assign sum_add     = {1'b0, sum} + {1'b0, rdata};
  assign in_prefix   = CW'(idx) < split_reg;
  assign up_prod_ovf = prod_up[PW-1:CNT_W] != '0;
  assign up_lt       = PW'(rdata) < prod_up;

  always_comb begin
    stat.n_le1       = pack_total <= CW'(1);
    stat.ratio_ovf   = prod_down[PW-1:CNT_W] != '0;
    stat.ratio_break = PW'(cur) < prod_down;
    stat.idx_one     = idx == IW'(1);
    stat.up_ovf      = in_prefix ? sum_add[CNT_W]
                                 : (up_prod_ovf || (up_lt && sum_add[CNT_W]));
    stat.up_stop     = !in_prefix && !up_prod_ovf && !up_lt;
    stat.up_last     = CW'(idx) == (pack_total - CW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pack_total   <= '0;
      factor       <= grs_pkg::FACTOR_RESET;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        factor <= cfg_data;
      end
      if (ram_we) begin
        pack_total <= pack_total + CW'(1);
      end
      result_valid <= cmd.finish;
      if (cmd.finish) begin
        pack_total <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.begin_scan) begin
      idx       <= IW'(pack_total - CW'(1));
      split_reg <= '0;
    end
    if (cmd.load_cur) begin
      cur <= rdata;
    end
    if (cmd.down_step) begin
      cur <= rdata;
      idx <= idx - IW'(1);
    end
    if (cmd.split_hi) begin
      split_reg <= CW'(idx) + CW'(1);
    end
    if (cmd.up_init) begin
      idx <= '0;
      sum <= '0;
    end
    if (cmd.up_step) begin
      sum <= sum_add[CNT_W-1:0];
      idx <= idx + IW'(1);
      if (!in_prefix) begin
        split_reg <= split_reg + CW'(1);
      end
    end
    if (cmd.finish) begin
      status    <= cmd.code;
      split_out <= (cmd.code == grs_pkg::STATUS_OK) ? split_reg : '0;
    end
  end

  assign split_wide = {{grs_pkg::SPLIT_W{1'b0}}, split_out};
  assign split      = split_wide[grs_pkg::SPLIT_W-1:0];

endmodule

`default_nettype wire

[sv/grs_ctrl.sv]
`default_nettype none

module grs_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic           last,
  input  wire grs_pkg::stat_t stat,
  output grs_pkg::cmd_t       cmd,
  output logic                busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BEGIN,
    S_DCUR,
    S_DLOW,
    S_USTART,
    S_URUN,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    cmd.code   = grs_pkg::STATUS_OK;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start && !busy) begin
          cmd.store = 1'b1;
          if (last) begin
            state_next = S_BEGIN;
          end
        end
      end
      S_BEGIN: begin
        cmd.begin_scan = 1'b1;
        state_next     = stat.n_le1 ? S_USTART : S_DCUR;
      end
      S_DCUR: begin
        cmd.load_cur = 1'b1;
        state_next   = S_DLOW;
      end
      S_DLOW: begin
        priority if (stat.ratio_ovf) begin
          cmd.finish = 1'b1;
          cmd.code   = grs_pkg::STATUS_RATIO_OVF;
          state_next = S_IDLE;
        end else if (stat.ratio_break) begin
          cmd.split_hi = 1'b1;
          state_next   = S_USTART;
        end else if (stat.idx_one) begin
          state_next = S_USTART;
        end else begin
          cmd.down_step = 1'b1;
        end
      end
      S_USTART: begin
        cmd.up_init = 1'b1;
        state_next  = S_URUN;
      end
      S_URUN: begin
        priority if (stat.up_ovf) begin
          cmd.finish = 1'b1;
          cmd.code   = grs_pkg::STATUS_SUM_OVF;
          state_next = S_IDLE;
        end else if (stat.up_stop) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.up_step = 1'b1;
          if (stat.up_last) begin
            state_next = S_OUT;
          end
        end
      end
      S_OUT: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= state_next != S_IDLE;
    end
  end

endmodule

`default_nettype wire
